/* rtl/bhq_pkg.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Payload types, operation codes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bhq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 11;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [EntryW-1:0]        entry_t;

  typedef enum logic {
    KindInsert  = 1'b0,
    KindExtract = 1'b1
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input item, clear result
    logic ins_start;  // hole at end of heap, count up
    logic rd_parent;  // read parent of hole
    logic up_step;    // parent moves down into hole
    logic put_val;    // moving value written into hole
    logic rd_root;    // read root
    logic take_root;  // capture root, count down, read last entry
    logic take_last;  // last entry becomes moving value, hole at root
    logic rd_left;    // read left child of hole
    logic take_left;  // capture left child, read right child
    logic down_step;  // larger child moves up into hole
    logic set_err;    // flag full/empty error
    logic publish;    // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  count_one;
    logic  parent_zero;
    logic  up_move;
    logic  left_in;
    logic  down_move;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/bhq_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one queue operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhq_in_if
  import bhq_pkg::*;
;
  logic   valid;
  logic   ready;
  kind_e  kind;
  value_t item_value;

  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

`default_nettype wire

/* rtl/bhq_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhq_out_if
  import bhq_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t out_value;
  logic   out_valid;
  logic   error_flag;
  entry_t entry_total;

  modport source (output valid, output out_value, output out_valid, output error_flag,
                  output entry_total, input ready);
  modport sink   (input valid, input out_value, input out_valid, input error_flag,
                  input entry_total, output ready);
endinterface

`default_nettype wire

/* rtl/bhq_dp.sv */
// ----------------------------------------------------------------------------
// Heap datapath
// Heap memory with one write and one registered read port, hole position,
// moving value, entry count, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bhq_dp
  import bhq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   cmd_i,
  output sts_t        sts_o,
  input  wire kind_e  kind_i,
  input  wire value_t item_value_i,
  output logic        out_vld_o,
  input  wire logic   out_rdy_i,
  output value_t      out_value_o,
  output logic        out_valid_o,
  output logic        error_flag_o,
  output entry_t      entry_total_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  value_t heap_mem_q [DEPTH];
  value_t rdata_q;

  kind_e           kind_q;
  value_t          val_q;
  value_t          left_q;
  logic [AW-1:0]   pos_q;
  logic [CW-1:0]   count_q;
  value_t          res_value_q;
  logic            res_valid_q;
  logic            res_err_q;
  logic            out_vld_q;
  value_t          out_value_q;
  logic            out_valid_q;
  logic            out_err_q;
  entry_t          out_total_q;

  logic [IW-1:0]   pos_w;
  logic [IW-1:0]   count_w;
  logic [IW-1:0]   left_idx;
  logic [IW-1:0]   right_idx;
  logic [AW-1:0]   parent_idx;
  logic            left_in;
  logic            right_in;
  logic            left_gt;
  logic            sel_right;
  value_t          child_val;
  logic [AW-1:0]   child_pos;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            we;
  value_t          wd;

  assign pos_w      = IW'(pos_q);
  assign count_w    = IW'(count_q);
  assign left_idx   = {pos_w[IW-2:0], 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign left_in    = left_idx < count_w;
  assign right_in   = right_idx < count_w;

  // left wins ties; right only when strictly larger than the current best
  assign left_gt   = left_q > val_q;
  assign sel_right = right_in && (rdata_q > (left_gt ? left_q : val_q));
  assign child_val = sel_right ? rdata_q : left_q;
  assign child_pos = sel_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    sts_o.kind        = kind_q;
    sts_o.full        = count_q == CW'(DEPTH);
    sts_o.empty       = count_q == '0;
    sts_o.count_one   = count_q == CW'(1);
    sts_o.parent_zero = parent_idx == '0;
    sts_o.up_move     = rdata_q < val_q;
    sts_o.left_in     = left_in;
    sts_o.down_move   = left_gt || sel_right;
    sts_o.out_free    = !out_vld_q || out_rdy_i;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.rd_parent) begin
      rd_en   = 1'b1;
      rd_addr = parent_idx;
    end else if (cmd_i.rd_root) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.take_root) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count_q - CW'(1));
    end else if (cmd_i.rd_left) begin
      rd_en   = 1'b1;
      rd_addr = left_idx[AW-1:0];
    end else if (cmd_i.take_left) begin
      rd_en   = 1'b1;
      rd_addr = right_idx[AW-1:0];
    end
  end

  always_comb begin
    we = cmd_i.up_step || cmd_i.put_val || cmd_i.down_step;
    wd = val_q;
    if (cmd_i.up_step) begin
      wd = rdata_q;
    end else if (cmd_i.down_step) begin
      wd = child_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[pos_q] <= wd;
    end
    if (rd_en) begin
      rdata_q <= heap_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.ins_start) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.take_root) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.publish) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q      <= kind_i;
      val_q       <= item_value_i;
      res_value_q <= '0;
      res_valid_q <= 1'b0;
      res_err_q   <= 1'b0;
    end
    if (cmd_i.set_err) begin
      res_err_q <= 1'b1;
    end
    if (cmd_i.take_root) begin
      res_value_q <= rdata_q;
      res_valid_q <= 1'b1;
    end
    if (cmd_i.take_last) begin
      val_q <= rdata_q;
    end
    if (cmd_i.take_left) begin
      left_q <= rdata_q;
    end
    if (cmd_i.ins_start) begin
      pos_q <= AW'(count_q);
    end else if (cmd_i.up_step) begin
      pos_q <= parent_idx;
    end else if (cmd_i.take_last) begin
      pos_q <= '0;
    end else if (cmd_i.down_step) begin
      pos_q <= child_pos;
    end
    if (cmd_i.publish) begin
      out_value_q <= res_value_q;
      out_valid_q <= res_valid_q;
      out_err_q   <= res_err_q;
      out_total_q <= EntryW'(count_q);
    end
  end

  assign out_vld_o     = out_vld_q;
  assign out_value_o   = out_value_q;
  assign out_valid_o   = out_valid_q;
  assign error_flag_o  = out_err_q;
  assign entry_total_o = out_total_q;

endmodule

`default_nettype wire

/* rtl/bhq_ctrl.sv */
// ----------------------------------------------------------------------------
// Heap controller
// Sequences one operation at a time: sift-up for insert, root removal and
// sift-down for extract, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhq_ctrl
  import bhq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [10:0] {
    SIdle  = 11'b000_0000_0001,
    SStart = 11'b000_0000_0010,
    SUpRd  = 11'b000_0000_0100,
    SUpCmp = 11'b000_0000_1000,
    SPut   = 11'b000_0001_0000,
    SRoot  = 11'b000_0010_0000,
    SLast  = 11'b000_0100_0000,
    SDnL   = 11'b000_1000_0000,
    SDnR   = 11'b001_0000_0000,
    SDnCmp = 11'b010_0000_0000,
    SDone  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == SIdle;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = SStart;
        end
      end
      SStart: begin
        if (sts_i.kind == KindInsert) begin
          if (sts_i.full) begin
            cmd_o.set_err = 1'b1;
            state_d       = SDone;
          end else begin
            cmd_o.ins_start = 1'b1;
            state_d         = sts_i.empty ? SPut : SUpRd;
          end
        end else begin
          if (sts_i.empty) begin
            cmd_o.set_err = 1'b1;
            state_d       = SDone;
          end else begin
            cmd_o.rd_root = 1'b1;
            state_d       = SRoot;
          end
        end
      end
      SUpRd: begin
        cmd_o.rd_parent = 1'b1;
        state_d         = SUpCmp;
      end
      SUpCmp: begin
        if (sts_i.up_move) begin
          cmd_o.up_step = 1'b1;
          state_d       = sts_i.parent_zero ? SPut : SUpRd;
        end else begin
          cmd_o.put_val = 1'b1;
          state_d       = SDone;
        end
      end
      SPut: begin
        cmd_o.put_val = 1'b1;
        state_d       = SDone;
      end
      SRoot: begin
        cmd_o.take_root = 1'b1;
        state_d         = sts_i.count_one ? SDone : SLast;
      end
      SLast: begin
        cmd_o.take_last = 1'b1;
        state_d         = SDnL;
      end
      SDnL: begin
        if (sts_i.left_in) begin
          cmd_o.rd_left = 1'b1;
          state_d       = SDnR;
        end else begin
          cmd_o.put_val = 1'b1;
          state_d       = SDone;
        end
      end
      SDnR: begin
        cmd_o.take_left = 1'b1;
        state_d         = SDnCmp;
      end
      SDnCmp: begin
        if (sts_i.down_move) begin
          cmd_o.down_step = 1'b1;
          state_d         = SDnL;
        end else begin
          cmd_o.put_val = 1'b1;
          state_d       = SDone;
        end
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/binary_max_heap_queue.sv */
// ----------------------------------------------------------------------------
// Binary max-heap queue
// Priority queue of signed 32-bit values held as a max-heap in on-chip RAM.
//
// in_i carries one operation per item: kind insert puts item_value in the
// heap, kind extract removes the largest value. out_o returns exactly one
// result per item: the removed maximum (out_valid set) or zero, the error
// flag for an insert into a full heap or an extract from an empty one, and
// the entry count after the operation.
// One item is worked at a time. An insert moves the value up level by
// level until it stops or reaches the root; an extract takes the root,
// moves the last entry into the hole at the root and moves it down until
// it stops or reaches a leaf, or only takes the root when it empties the
// heap. The controller passes through idle before the next item. The heap
// RAM gives one registered read and one write per cycle; going down takes
// two reads per level. A value moves at most log2(DEPTH) levels.
// Reset empties the heap at once; RAM contents are not cleared.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result waits until out_o.ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue
  import bhq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bhq_in_if.sink    in_i,
  bhq_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  bhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bhq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (in_i.kind),
    .item_value_i  (in_i.item_value),
    .out_vld_o     (out_o.valid),
    .out_rdy_i     (out_o.ready),
    .out_value_o   (out_o.out_value),
    .out_valid_o   (out_o.out_valid),
    .error_flag_o  (out_o.error_flag),
    .entry_total_o (out_o.entry_total)
  );

endmodule

`default_nettype wire

/* rtl/bhq_chk.sv */
// ----------------------------------------------------------------------------
// Heap queue port checker
// Watches the top-level channels for result accounting and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bhq_chk
  import bhq_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_valid_i,
  input wire logic   in_ready_i,
  input wire logic   out_vld_i,
  input wire logic   out_rdy_i,
  input wire value_t out_value_i,
  input wire logic   out_valid_i,
  input wire logic   error_flag_i
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_vld_i && out_rdy_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_rdy_i |=> out_vld_i)
    else $error("result dropped while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result delivered with no item outstanding");

  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && out_valid_i |-> !error_flag_i)
    else $error("extracted value flagged as error");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_valid_i |-> out_value_i == '0)
    else $error("non-zero value without extraction");

endmodule

bind binary_max_heap_queue bhq_chk u_bhq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_vld_i    (out_o.valid),
  .out_rdy_i    (out_o.ready),
  .out_value_i  (out_o.out_value),
  .out_valid_i  (out_o.out_valid),
  .error_flag_i (out_o.error_flag)
);

`default_nettype wire
